FILE: src/tlb_page_table_translator_defines.svh
// Assertion macros for the TLB page table translator.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define TLBPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define TLBPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tlbpt_pkg.sv
// Shared constants and control bundles for the TLB page table translator.
package tlbpt_pkg;

  // Fixed port field widths
  localparam int VA_W = 16;
  localparam int PA_W = 15;
  localparam int FI_W = 7;
  localparam int EP_W = 8;

  // Default sizing (PAGE_BYTES and NUM_PAGES are powers of two)
  localparam int DEF_TLB_ENTRIES = 16;
  localparam int DEF_NUM_PAGES   = 256;
  localparam int DEF_NUM_FRAMES  = 128;
  localparam int DEF_PAGE_BYTES  = 256;
  localparam int DEF_AGE_BITS    = 16;

  // Commands from the sequencer to the TLB
  typedef struct packed {
    logic touch_hit;
    logic invalidate;
    logic scan_start;
    logic refill;
  } tlb_ctl_t;

  // Commands from the sequencer to the frame allocator
  typedef struct packed {
    logic sweep_start;
    logic own_read;
    logic commit;
  } frm_ctl_t;

endpackage

FILE: src/tlbpt_tlb.sv
// Fully associative TLB with LRU ages and a sequential victim scan.
module tlbpt_tlb
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int PG_W        = 8,
  parameter int FR_W        = 7,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tlb_ctl_t        ctl,
  input  logic [PG_W-1:0] look_page,
  input  logic [FR_W-1:0] fill_frame,
  input  logic [FR_W-1:0] inval_frame,
  output logic            hit,
  output logic [FR_W-1:0] hit_frame,
  output logic            scan_done
);

  localparam int TW = $clog2(TLB_ENTRIES);
  localparam logic [TW-1:0] LAST = TW'(TLB_ENTRIES - 1);

  logic [PG_W-1:0]     tag_r [TLB_ENTRIES];
  logic [FR_W-1:0]     frm_r [TLB_ENTRIES];
  logic [AGE_BITS-1:0] age_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] vld_r;

  logic                busy_r;
  logic                done_r;
  logic [TW-1:0]       sidx_r;
  logic [TW-1:0]       best_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic [TW-1:0]       vic_r;

  logic [TW-1:0]       hit_idx;
  logic                any_inv;
  logic [TW-1:0]       first_inv;
  logic [AGE_BITS-1:0] age_sel;
  logic                sel_older;

  function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  // Tag match, lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (vld_r[i] && (tag_r[i] == look_page)) begin
        hit     = 1'b1;
        hit_idx = TW'(i);
      end
    end
  end

  assign hit_frame = frm_r[hit_idx];

  // Lowest free entry
  always_comb begin
    first_inv = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        first_inv = TW'(i);
      end
    end
  end

  assign any_inv   = ~&vld_r;
  assign age_sel   = age_r[sidx_r];
  assign sel_older = age_sel > best_age_r;
  assign scan_done = done_r;

  // Entry updates and the one-entry-a-cycle oldest search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        age_r[i] <= '1;
      end
    end else begin
      if (ctl.touch_hit) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (vld_r[i]) begin
            age_r[i] <= sat_inc(age_r[i]);
          end
        end
        age_r[hit_idx] <= '0;
      end
      if (ctl.invalidate) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (vld_r[i] && (frm_r[i] == inval_frame)) begin
            vld_r[i] <= 1'b0;
            age_r[i] <= '1;
          end
        end
      end
      if (ctl.scan_start) begin
        done_r <= 1'b0;
        if (any_inv) begin
          vic_r  <= first_inv;
          done_r <= 1'b1;
        end else begin
          busy_r     <= 1'b1;
          sidx_r     <= TW'(1);
          best_r     <= '0;
          best_age_r <= age_r[0];
        end
      end
      if (busy_r) begin
        if (sel_older) begin
          best_r     <= sidx_r;
          best_age_r <= age_sel;
        end
        if (sidx_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          vic_r  <= sel_older ? sidx_r : best_r;
        end else begin
          sidx_r <= sidx_r + 1'b1;
        end
      end
      if (ctl.refill) begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
          if (vld_r[i]) begin
            age_r[i] <= sat_inc(age_r[i]);
          end
        end
        age_r[vic_r] <= '0;
        tag_r[vic_r] <= look_page;
        frm_r[vic_r] <= fill_frame;
        vld_r[vic_r] <= 1'b1;
      end
    end
  end

endmodule

FILE: src/tlbpt_frames.sv
// Frame allocator: load-age memory with a read-modify-write sweep, owner memory.
module tlbpt_frames
  import tlbpt_pkg::*;
#(
  parameter int NUM_FRAMES = DEF_NUM_FRAMES,
  parameter int PG_W       = 8,
  parameter int FR_W       = 7,
  parameter int AGE_BITS   = DEF_AGE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  frm_ctl_t        ctl,
  input  logic [PG_W-1:0] new_page,
  output logic [FR_W-1:0] victim,
  output logic            full,
  output logic [PG_W-1:0] owner_page,
  output logic            sweep_done
);

  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam logic [CNT_W-1:0] NF       = CNT_W'(NUM_FRAMES);
  localparam logic [CNT_W-1:0] LAST_RD  = CNT_W'(NUM_FRAMES - 1);
  localparam logic [FR_W-1:0]  LAST_FR  = FR_W'(NUM_FRAMES - 1);

  logic [AGE_BITS-1:0] age_mem [NUM_FRAMES];
  logic [PG_W-1:0]     own_mem [NUM_FRAMES];

  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    ridx_r;
  logic                rbusy_r;
  logic                pv_r;
  logic [FR_W-1:0]     pidx_r;
  logic [AGE_BITS-1:0] age_rd_r;
  logic [PG_W-1:0]     own_rd_r;
  logic                have_r;
  logic [FR_W-1:0]     best_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic                done_r;

  logic                in_use;
  logic                age_we;
  logic [FR_W-1:0]     age_wa;
  logic [AGE_BITS-1:0] age_wd;

  // Frames are handed out in order and never freed, so the fill count
  // gives both the in-use bits and the lowest free frame.
  assign full       = (fill_r == NF);
  assign victim     = full ? best_r : fill_r[FR_W-1:0];
  assign in_use     = (CNT_W'(pidx_r) < fill_r);
  assign owner_page = own_rd_r;
  assign sweep_done = done_r;

  // Age write port: sweep write-back or reset of the loaded frame
  always_comb begin
    age_we = pv_r && in_use;
    age_wa = pidx_r;
    age_wd = (&age_rd_r) ? age_rd_r : age_rd_r + 1'b1;
    if (ctl.commit) begin
      age_we = 1'b1;
      age_wa = victim;
      age_wd = '0;
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    if (rbusy_r) begin
      age_rd_r <= age_mem[ridx_r[FR_W-1:0]];
    end
    if (ctl.commit) begin
      own_mem[victim] <= new_page;
    end
    if (ctl.own_read) begin
      own_rd_r <= own_mem[victim];
    end
  end

  // Sweep: read one frame a cycle, age it and track the oldest
  always_ff @(posedge clk) begin
    pidx_r <= ridx_r[FR_W-1:0];
    if (!rst_n) begin
      fill_r  <= '0;
      rbusy_r <= 1'b0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      pv_r <= rbusy_r;
      if (ctl.sweep_start) begin
        rbusy_r <= 1'b1;
        ridx_r  <= '0;
        done_r  <= 1'b0;
        have_r  <= 1'b0;
      end else if (rbusy_r) begin
        ridx_r <= ridx_r + 1'b1;
        if (ridx_r == LAST_RD) begin
          rbusy_r <= 1'b0;
        end
      end
      if (pv_r) begin
        if (in_use && (!have_r || (age_rd_r > best_age_r))) begin
          have_r     <= 1'b1;
          best_r     <= pidx_r;
          best_age_r <= age_rd_r;
        end
        if (pidx_r == LAST_FR) begin
          done_r <= 1'b1;
        end
      end
      if (ctl.commit && !full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

endmodule

FILE: src/tlb_page_table_translator.sv
// Top level: sequencer, page table memory and result register.
// A TLB hit is answered straight from the lookup; a page table hit waits for the
// TLB victim scan (skipped while an entry is free); a page fault also waits for
// the frame age sweep, and for an eviction when all frames are in use.
// One item at a time; the next is taken once the result is in the output register.
// Reset is synchronous; afterwards the page table is cleared entry by entry, input stalled.
`include "tlb_page_table_translator_defines.svh"
module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [VA_W-1:0] in_virtual_address,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [PA_W-1:0] out_physical_address,
  output logic [FI_W-1:0] out_frame_index,
  output logic            out_tlb_hit,
  output logic            out_page_fault,
  output logic            out_evict_valid,
  output logic [EP_W-1:0] out_evicted_page
);

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int PG_W  = $clog2(NUM_PAGES);
  localparam int FR_W  = $clog2(NUM_FRAMES);
  localparam int PT_W  = FR_W + 1;
  localparam logic [PG_W-1:0] LAST_PG = PG_W'(NUM_PAGES - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_LOOK  = 10'b00_0000_0100,
    S_SWEEP = 10'b00_0000_1000,
    S_OWNRD = 10'b00_0001_0000,
    S_EVICT = 10'b00_0010_0000,
    S_PTWR  = 10'b00_0100_0000,
    S_TSCAN = 10'b00_1000_0000,
    S_EMIT  = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [PT_W-1:0] pt_mem [NUM_PAGES];
  logic [PT_W-1:0] pt_rd_r;
  logic            pt_we;
  logic [PG_W-1:0] pt_wa;
  logic [PT_W-1:0] pt_wd;

  logic [PG_W-1:0]  clr_r;
  logic [PG_W-1:0]  page_r;
  logic [OFF_W-1:0] off_r;
  logic [FR_W-1:0]  frame_r;
  logic             res_hit_r;
  logic             res_fault_r;
  logic             res_evict_r;
  logic [PG_W-1:0]  res_evp_r;

  logic            out_valid_r;
  logic [PA_W-1:0] out_pa_r;
  logic [FI_W-1:0] out_fi_r;
  logic            out_hit_r;
  logic            out_fault_r;
  logic            out_evict_r;
  logic [EP_W-1:0] out_evp_r;

  logic [31:0]      va_shift;
  logic [PG_W-1:0]  in_page;
  logic             in_xfer;
  logic             out_free;
  logic             out_load;
  logic             look_hit;

  tlb_ctl_t        tlb_ctl;
  frm_ctl_t        frm_ctl;
  logic            tlb_hit;
  logic [FR_W-1:0] tlb_hit_frame;
  logic            tlb_scan_done;
  logic [FR_W-1:0] frm_victim;
  logic            frm_full;
  logic [PG_W-1:0] frm_owner;
  logic            frm_sweep_done;

  logic [FR_W-1:0] ld_frame;
  logic            ld_hit;
  logic            ld_fault;
  logic            ld_evict;
  logic [PG_W-1:0] ld_evp;
  logic [31:0]     pa32;
  logic [31:0]     fi32;
  logic [31:0]     evp32;

  // Address split
  assign va_shift = 32'(in_virtual_address) >> OFF_W;
  assign in_page  = va_shift[PG_W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign look_hit = (state_r == S_LOOK) && tlb_hit;

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PG_W        (PG_W),
    .FR_W        (FR_W),
    .AGE_BITS    (AGE_BITS)
  ) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (tlb_ctl),
    .look_page   (page_r),
    .fill_frame  (frame_r),
    .inval_frame (frame_r),
    .hit         (tlb_hit),
    .hit_frame   (tlb_hit_frame),
    .scan_done   (tlb_scan_done)
  );

  tlbpt_frames #(
    .NUM_FRAMES (NUM_FRAMES),
    .PG_W       (PG_W),
    .FR_W       (FR_W),
    .AGE_BITS   (AGE_BITS)
  ) u_frames (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (frm_ctl),
    .new_page   (page_r),
    .victim     (frm_victim),
    .full       (frm_full),
    .owner_page (frm_owner),
    .sweep_done (frm_sweep_done)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    tlb_ctl   = '0;
    frm_ctl   = '0;
    pt_we     = 1'b0;
    pt_wa     = page_r;
    pt_wd     = {1'b1, frame_r};
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        pt_we = 1'b1;
        pt_wa = clr_r;
        pt_wd = '0;
        if (clr_r == LAST_PG) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (tlb_hit) begin
          tlb_ctl.touch_hit = 1'b1;
          out_load          = out_free;
          state_nxt         = out_free ? S_IDLE : S_EMIT;
        end else if (pt_rd_r[FR_W]) begin
          tlb_ctl.scan_start = 1'b1;
          state_nxt          = S_TSCAN;
        end else begin
          frm_ctl.sweep_start = 1'b1;
          state_nxt           = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (frm_sweep_done) begin
          state_nxt = frm_full ? S_OWNRD : S_PTWR;
        end
      end
      S_OWNRD: begin
        frm_ctl.own_read = 1'b1;
        state_nxt        = S_EVICT;
      end
      S_EVICT: begin
        pt_we              = 1'b1;
        pt_wa              = frm_owner;
        pt_wd              = '0;
        tlb_ctl.invalidate = 1'b1;
        state_nxt          = S_PTWR;
      end
      S_PTWR: begin
        pt_we              = 1'b1;
        frm_ctl.commit     = 1'b1;
        tlb_ctl.scan_start = 1'b1;
        state_nxt          = S_TSCAN;
      end
      S_TSCAN: begin
        if (tlb_scan_done) begin
          tlb_ctl.refill = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        out_load = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Page table memory
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_wa] <= pt_wd;
    end
    if (in_xfer) begin
      pt_rd_r <= pt_mem[in_page];
    end
  end

  // State and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r <= in_page;
      off_r  <= in_virtual_address[OFF_W-1:0];
    end
    if (state_r == S_LOOK) begin
      res_hit_r   <= tlb_hit;
      res_fault_r <= !tlb_hit && !pt_rd_r[FR_W];
      res_evict_r <= 1'b0;
      res_evp_r   <= '0;
      frame_r     <= tlb_hit ? tlb_hit_frame : pt_rd_r[FR_W-1:0];
    end
    if ((state_r == S_SWEEP) && frm_sweep_done) begin
      frame_r     <= frm_victim;
      res_evict_r <= frm_full;
    end
    if (state_r == S_EVICT) begin
      res_evp_r <= frm_owner;
    end
  end

  // Result selection: straight from the TLB on a hit in the lookup state, else the working registers
  assign ld_frame = look_hit ? tlb_hit_frame : frame_r;
  assign ld_hit   = look_hit ? 1'b1 : res_hit_r;
  assign ld_fault = look_hit ? 1'b0 : res_fault_r;
  assign ld_evict = look_hit ? 1'b0 : res_evict_r;
  assign ld_evp   = look_hit ? '0 : res_evp_r;
  assign pa32     = (32'(ld_frame) << OFF_W) | 32'(off_r);
  assign fi32     = 32'(ld_frame);
  assign evp32    = 32'(ld_evp);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_pa_r    <= pa32[PA_W-1:0];
      out_fi_r    <= fi32[FI_W-1:0];
      out_hit_r   <= ld_hit;
      out_fault_r <= ld_fault;
      out_evict_r <= ld_evict;
      out_evp_r   <= evp32[EP_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_frame_index      = out_fi_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_evict_valid      = out_evict_r;
  assign out_evicted_page     = out_evp_r;

  // Checks
  `TLBPT_ASSERT_IMP(a_hit_no_fault, out_valid && out_tlb_hit, !out_page_fault && !out_evict_valid, "TLB hit reported with a fault or eviction")
  `TLBPT_ASSERT_IMP(a_evict_needs_fault, out_valid && out_evict_valid, out_page_fault, "eviction reported without a page fault")
  `TLBPT_ASSERT_NXT(a_busy_after_xfer, in_valid && !in_stall, in_stall, "input taken while an item is in flight")

endmodule

FILE: tb/sv/tlb_page_table_translator_tb.sv
// Self-checking testbench for the TLB page table translator.
module tlb_page_table_translator_tb
  import tlbpt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_N    = DEF_TLB_ENTRIES;
  localparam int PAGES_N  = DEF_NUM_PAGES;
  localparam int FRAMES_N = DEF_NUM_FRAMES;
  localparam int PB       = DEF_PAGE_BYTES;
  localparam int AGE_MAX  = (1 << DEF_AGE_BITS) - 1;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic [FI_W-1:0] frame;
    logic            hit;
    logic            fault;
    logic            evict;
    logic [EP_W-1:0] evicted;
  } xlat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VA_W-1:0] in_virtual_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PA_W-1:0] out_physical_address;
  logic [FI_W-1:0] out_frame_index;
  logic out_tlb_hit, out_page_fault, out_evict_valid;
  logic [EP_W-1:0] out_evicted_page;

  tlb_page_table_translator dut (.*);

  always #5 clk = ~clk;

  // Translator state mirror
  logic [7:0]  tag_m [TLB_N];
  logic [6:0]  tfrm_m [TLB_N];
  bit          tval_m [TLB_N];
  int          tage_m [TLB_N];
  logic [6:0]  p2f_m [PAGES_N];
  bit          pres_m [PAGES_N];
  int          fage_m [FRAMES_N];
  bit          fuse_m [FRAMES_N];
  logic [7:0]  fown_m [FRAMES_N];

  xlat_t expected_xlat[$];
  int errors = 0, n_sent = 0, n_hits = 0, n_faults = 0, n_evicts = 0, idle_cycles = 0;
  bit burst_mode = 1'b1;

  function automatic int sat_inc(int a);
    return (a >= AGE_MAX) ? AGE_MAX : a + 1;
  endfunction

  function automatic void touch_tlb(int idx);
    for (int i = 0; i < TLB_N; i++) if (tval_m[i]) tage_m[i] = sat_inc(tage_m[i]);
    tage_m[idx] = 0;
  endfunction

  function automatic xlat_t translate(logic [15:0] va);
    xlat_t r;
    int page, offs, frm, vict, best;
    page = (va / PB) % PAGES_N;
    offs = va % PB;
    r = '0;
    frm = 0;
    for (int i = 0; i < TLB_N; i++) begin
      if (tval_m[i] && tag_m[i] == page) begin
        r.hit = 1'b1;
        frm = tfrm_m[i];
        touch_tlb(i);
        break;
      end
    end
    if (!r.hit) begin
      if (pres_m[page]) begin
        frm = p2f_m[page];
      end else begin
        r.fault = 1'b1;
        frm = -1;
        for (int i = 0; i < FRAMES_N; i++) if (!fuse_m[i] && frm < 0) frm = i;
        if (frm < 0) begin
          best = 0;
          for (int i = 1; i < FRAMES_N; i++) if (fage_m[i] > fage_m[best]) best = i;
          frm = best;
          r.evict = 1'b1;
          r.evicted = fown_m[frm];
          pres_m[fown_m[frm]] = 1'b0;
          for (int i = 0; i < TLB_N; i++) begin
            if (tval_m[i] && tfrm_m[i] == frm) begin
              tval_m[i] = 1'b0;
              tage_m[i] = AGE_MAX;
            end
          end
        end
        for (int i = 0; i < FRAMES_N; i++) if (fuse_m[i]) fage_m[i] = sat_inc(fage_m[i]);
        fage_m[frm] = 0;
        fuse_m[frm] = 1'b1;
        fown_m[frm] = 8'(page);
        p2f_m[page] = 7'(frm);
        pres_m[page] = 1'b1;
      end
      vict = -1;
      for (int i = 0; i < TLB_N; i++) if (!tval_m[i] && vict < 0) vict = i;
      if (vict < 0) begin
        vict = 0;
        for (int i = 1; i < TLB_N; i++) if (tage_m[i] > tage_m[vict]) vict = i;
      end
      touch_tlb(vict);
      tag_m[vict] = 8'(page);
      tfrm_m[vict] = 7'(frm);
      tval_m[vict] = 1'b1;
    end
    r.frame = FI_W'(frm);
    r.pa = PA_W'(frm * PB + offs);
    return r;
  endfunction

  // Send one address; random gaps between bursts
  task automatic send_va(logic [15:0] va);
    if (!burst_mode || $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_virtual_address <= va;
    do @(posedge clk); while (in_stall);
    expected_xlat.push_back(translate(va));
    n_sent++;
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (burst_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 2) == 0);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      xlat_t got, want;
      got = '{out_physical_address, out_frame_index, out_tlb_hit, out_page_fault,
              out_evict_valid, out_evicted_page};
      if (expected_xlat.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_xlat.pop_front();
        if (want.hit) n_hits++;
        if (want.fault) n_faults++;
        if (want.evict) n_evicts++;
        if (got.pa !== want.pa)
          $display("%0t: physical_address exp %h got %h", $time, want.pa, got.pa);
        if (got.frame !== want.frame)
          $display("%0t: frame_index exp %h got %h", $time, want.frame, got.frame);
        if (got.hit !== want.hit)
          $display("%0t: tlb_hit exp %b got %b", $time, want.hit, got.hit);
        if (got.fault !== want.fault)
          $display("%0t: page_fault exp %b got %b", $time, want.fault, got.fault);
        if (got.evict !== want.evict)
          $display("%0t: evict_valid exp %b got %b", $time, want.evict, got.evict);
        if (got.evicted !== want.evicted)
          $display("%0t: evicted_page exp %h got %h", $time, want.evicted, got.evicted);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Extremes of the address and hits on a freshly loaded page
  task automatic test_directed();
    send_va(16'h0000);
    send_va(16'h00FF);
    send_va(16'hFFFF);
    send_va(16'hFF00);
    send_va(16'h5AA5);
    send_va(16'hA55A);
    send_va(16'h0080);
  endtask

  // More than TLB_N pages cycled to force TLB replacement and page table hits
  task automatic test_tlb_replacement();
    for (int i = 0; i < 20; i++) send_va({8'(i + 16), 8'($urandom)});
    for (int i = 0; i < 8; i++) send_va({8'(i + 16), 8'($urandom)});
  endtask

  // Fill all frames and overflow them to force evictions
  task automatic test_eviction();
    for (int i = 0; i < 200; i++) send_va(16'($urandom));
  endtask

  // Mostly a working set of nearby pages, some wide scatter
  task automatic test_random(int count);
    int base;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        burst_mode = 1'($urandom_range(0, 1));
        base = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 3) == 0) send_va(16'($urandom));
      else send_va({8'(base + $urandom_range(0, 20)), 8'($urandom)});
    end
  endtask

  initial begin
    foreach (tval_m[i]) begin
      tval_m[i] = 1'b0; tage_m[i] = AGE_MAX; tag_m[i] = '0; tfrm_m[i] = '0;
    end
    foreach (pres_m[i]) begin
      pres_m[i] = 1'b0; p2f_m[i] = '0;
    end
    foreach (fuse_m[i]) begin
      fuse_m[i] = 1'b0; fage_m[i] = 0; fown_m[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_tlb_replacement();
    burst_mode = 1'b0;
    test_eviction();
    test_random(970);
    in_valid <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d addresses: %0d TLB hits, %0d page faults, %0d evictions.",
             n_sent, n_hits, n_faults, n_evicts);
    if (errors == 0 && expected_xlat.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
